// File: hdl/ppbd_pkg.sv
// shared types, constants and register codes of the pulse peak and rate detector
package ppbd_pkg;

	localparam int AVG_DEPTH_DEF = 5;

	localparam int SAMPLE_W    = 16;
	localparam int TICK_W      = 32;
	localparam int RATE_W      = 20;
	localparam int PEAK_W      = 7;
	localparam int DIVISOR_W   = 32;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic signed [SAMPLE_W-1:0] MIN_LEVEL_RST    = 16'sd358;
	localparam logic signed [SAMPLE_W-1:0] MAX_LEVEL_RST    = 16'sd768;
	localparam logic [15:0]                MINUTE_TICKS_RST = 16'd60000;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_MIN_LEVEL    = 2'd0;
	localparam logic [1:0] REG_MAX_LEVEL    = 2'd1;
	localparam logic [1:0] REG_MINUTE_TICKS = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [TICK_W-1:0]          tick_now;
	} in_item_t;

	typedef struct packed {
		logic              beat;
		logic [RATE_W-1:0] rate;
		logic [PEAK_W-1:0] peak_level;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_RISING  = 3'b010,
		PH_FALLING = 3'b100
	} phase_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RATE = 5'b00010,
		ST_HIST = 5'b00100,
		ST_AVG  = 5'b01000,
		ST_DONE = 5'b10000
	} seq_state_t;

endpackage

// File: hdl/ppbd_div.sv
// shared restoring divider, one quotient bit per cycle
module ppbd_div #(
	parameter int NW = 23
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [NW-1:0]                  dividend,
	input  logic [ppbd_pkg::DIVISOR_W-1:0] divisor,
	output logic [NW-1:0]                  quotient,
	output ppbd_pkg::div_stat_t            stat
);

	localparam int DW    = ppbd_pkg::DIVISOR_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits DW bits
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: hdl/pulse_peak_bpm_detector.sv
// pulse peak tracker with rate history, sequenced around one shared divider
// an item without a beat moves straight to the done state, then into the output register once the output can take it
// a beat item runs two serial divisions on the shared divider, the rate and then the average
// in_stall stays high from a transfer until its result is in the output register
// a beat with a zero interval skips the rate division and records a rate of zero
// async reset loads the default levels and clears tracker, history and output valid flag
module pulse_peak_bpm_detector #(
	parameter int AVG_DEPTH = ppbd_pkg::AVG_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  ppbd_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ppbd_pkg::out_item_t          out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppbd_pkg::PADDR_W-1:0] paddr,
	input  logic [ppbd_pkg::PDATA_W-1:0] pwdata,
	output logic [ppbd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int RATE_W = ppbd_pkg::RATE_W;
	localparam int PEAK_W = ppbd_pkg::PEAK_W;
	localparam int TICK_W = ppbd_pkg::TICK_W;
	localparam int SMP_W  = ppbd_pkg::SAMPLE_W;
	localparam int PTR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W  = RATE_W + $clog2(AVG_DEPTH + 1);

	// configuration registers
	logic signed [SMP_W-1:0] min_level_q;
	logic signed [SMP_W-1:0] max_level_q;
	logic [15:0]             minute_ticks_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q    <= ppbd_pkg::MIN_LEVEL_RST;
			max_level_q    <= ppbd_pkg::MAX_LEVEL_RST;
			minute_ticks_q <= ppbd_pkg::MINUTE_TICKS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				ppbd_pkg::REG_MIN_LEVEL:    min_level_q    <= pwdata[15:0];
				ppbd_pkg::REG_MAX_LEVEL:    max_level_q    <= pwdata[15:0];
				ppbd_pkg::REG_MINUTE_TICKS: minute_ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ppbd_pkg::REG_MIN_LEVEL:    prdata = {16'd0, min_level_q};
			ppbd_pkg::REG_MAX_LEVEL:    prdata = {16'd0, max_level_q};
			ppbd_pkg::REG_MINUTE_TICKS: prdata = {16'd0, minute_ticks_q};
			default:                    prdata = '0;
		endcase
	end

	// tracker and sequencer state
	ppbd_pkg::seq_state_t    state_q;
	ppbd_pkg::phase_t        phase_q;
	logic signed [SMP_W-1:0] prev_q;
	logic [TICK_W-1:0]       cur_tick_q;
	logic [TICK_W-1:0]       last_tick_q;
	logic [PEAK_W-1:0]       peak_q;
	logic [RATE_W-1:0]       hist_q [AVG_DEPTH];
	logic [PTR_W-1:0]        ptr_q;
	logic [FILL_W-1:0]       fill_q;
	logic [SUM_W-1:0]        sum_q;
	logic [RATE_W-1:0]       avg_q;
	logic [RATE_W-1:0]       raw_q;
	logic                    beat_q;
	logic                    out_valid_q;
	ppbd_pkg::out_item_t     out_q;

	logic                    accept;
	logic signed [SMP_W-1:0] s;
	logic                    over_max;
	logic                    is_beat;
	logic [TICK_W-1:0]       interval;
	logic [PEAK_W-1:0]       peak_new;
	logic [SUM_W-1:0]        sum_new;
	logic [FILL_W-1:0]       fill_new;
	logic                    out_load;

	logic                           div_start;
	logic [SUM_W-1:0]               div_dividend;
	logic [ppbd_pkg::DIVISOR_W-1:0] div_divisor;
	logic [SUM_W-1:0]               div_quotient;
	ppbd_pkg::div_stat_t            div_stat;

	assign in_stall = (state_q != ppbd_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign s        = in_item.sample;
	assign over_max = s > max_level_q;
	assign is_beat  = !over_max && (phase_q == ppbd_pkg::PH_RISING) && !(s > prev_q);
	assign interval = cur_tick_q - last_tick_q;
	// integer part of the new high, negatives clamp to zero
	assign peak_new = s[SMP_W-1] ? '0 : s[14:8];

	assign sum_new  = sum_q - SUM_W'(hist_q[ptr_q]) + SUM_W'(raw_q);
	assign fill_new = (fill_q == FILL_W'(AVG_DEPTH)) ? fill_q : fill_q + 1'b1;
	assign out_load = (state_q == ppbd_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	assign div_start = (accept && is_beat && (interval != '0)) || (state_q == ppbd_pkg::ST_HIST);
	always_comb begin
		if (state_q == ppbd_pkg::ST_HIST) begin
			div_dividend = sum_new;
			div_divisor  = ppbd_pkg::DIVISOR_W'(fill_new);
		end else begin
			div_dividend = SUM_W'({minute_ticks_q, 4'd0});
			div_divisor  = interval;
		end
	end

	ppbd_div #(
		.NW(SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppbd_pkg::ST_IDLE;
			phase_q     <= ppbd_pkg::PH_IDLE;
			prev_q      <= '0;
			cur_tick_q  <= '0;
			last_tick_q <= '0;
			peak_q      <= '0;
			for (int i = 0; i < AVG_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			ptr_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			raw_q       <= '0;
			beat_q      <= 1'b0;
		end else begin
			case (state_q)
				ppbd_pkg::ST_IDLE: begin
					if (accept) begin
						beat_q  <= 1'b0;
						state_q <= ppbd_pkg::ST_DONE;
						if (over_max) begin
							phase_q     <= ppbd_pkg::PH_IDLE;
							prev_q      <= '0;
							cur_tick_q  <= '0;
							last_tick_q <= '0;
							peak_q      <= '0;
						end else if (is_beat) begin
							// previous sample is left as it was on a beat
							last_tick_q <= cur_tick_q;
							phase_q     <= ppbd_pkg::PH_FALLING;
							beat_q      <= 1'b1;
							if (interval == '0) begin
								raw_q   <= '0;
								state_q <= ppbd_pkg::ST_HIST;
							end else begin
								state_q <= ppbd_pkg::ST_RATE;
							end
						end else begin
							prev_q <= s;
							case (phase_q)
								ppbd_pkg::PH_IDLE: begin
									if (s >= min_level_q) begin
										phase_q <= ppbd_pkg::PH_RISING;
									end
								end
								ppbd_pkg::PH_RISING: begin
									cur_tick_q <= in_item.tick_now;
									peak_q     <= peak_new;
								end
								ppbd_pkg::PH_FALLING: begin
									if (s < min_level_q) begin
										phase_q <= ppbd_pkg::PH_IDLE;
									end
								end
								default: phase_q <= ppbd_pkg::PH_IDLE;
							endcase
						end
					end
				end
				ppbd_pkg::ST_RATE: begin
					if (div_stat.done) begin
						raw_q   <= div_quotient[RATE_W-1:0];
						state_q <= ppbd_pkg::ST_HIST;
					end
				end
				ppbd_pkg::ST_HIST: begin
					// running sum swaps the oldest entry for the new one
					hist_q[ptr_q] <= raw_q;
					sum_q         <= sum_new;
					fill_q        <= fill_new;
					ptr_q         <= (ptr_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
					state_q       <= ppbd_pkg::ST_AVG;
				end
				ppbd_pkg::ST_AVG: begin
					if (div_stat.done) begin
						avg_q   <= div_quotient[RATE_W-1:0];
						state_q <= ppbd_pkg::ST_DONE;
					end
				end
				ppbd_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= ppbd_pkg::ST_IDLE;
					end
				end
				default: state_q <= ppbd_pkg::ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.beat       <= beat_q;
			out_q.rate       <= avg_q;
			out_q.peak_level <= peak_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_div_busy_in_div_state : assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ppbd_pkg::ST_RATE || state_q == ppbd_pkg::ST_AVG))
		else $error("divider busy outside a division step");

	a_avg_done_to_out : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppbd_pkg::ST_AVG && div_stat.done) |=> state_q == ppbd_pkg::ST_DONE)
		else $error("average quotient not handed to output stage");

	a_beat_has_history : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.beat) |-> fill_q != '0)
		else $error("beat reported with empty rate history");

	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppbd_pkg::ST_HIST) |=> (fill_q != '0 && fill_q <= FILL_W'(AVG_DEPTH)))
		else $error("history fill count out of range");

endmodule
